// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the box overlap scan.
// No dependencies; the checks fall away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition that must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hw/rtl/lbos_pkg.sv -----
// Shared types and constants of the layered box overlap scan.
// No dependencies; used by the controller, the datapath and the top level.
package lbos_pkg;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SCAN  = 1'b1;

    // Field widths
    localparam int IDX_W   = 3;
    localparam int LAYER_W = 4;
    localparam int POS_W   = 16;
    localparam int EXT_W   = 15;
    // Edge in Q.1: 2*centre +/- size
    localparam int EDGE_W  = POS_W + 2;
    // 2*(size_a + size_b)
    localparam int SPAN_W  = EXT_W + 2;

    // One stored box slot
    typedef struct packed {
        logic [EXT_W-1:0]   extent_y;
        logic [EXT_W-1:0]   extent_x;
        logic [POS_W-1:0]   centre_y;
        logic [POS_W-1:0]   centre_x;
        logic [LAYER_W-1:0] layer_to;
        logic [LAYER_W-1:0] layer_from;
        logic               handler;
        logic               enabled;
    } slot_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic issue;
        logic wr_en;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic adv;
        logic pair_last;
        logic done;
    } status_t;

endpackage

// ----- hw/rtl/lbos_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module lbos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports, hold while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- hw/rtl/lbos_ctrl.sv -----
// Controller of the box overlap scan: request handshake and scan sequencing.
// Depends on lbos_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lbos_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    output lbos_pkg::cmd_t     cmd,
    input  lbos_pkg::status_t  status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;
    logic   accept;

    // Take a request only while idle
    assign accept    = in_valid && !stall_reg;
    assign in_stall  = stall_reg;
    assign cmd.wr_en = accept && (req_type == lbos_pkg::REQ_WRITE);
    assign cmd.start = accept && (req_type == lbos_pkg::REQ_SCAN);
    assign cmd.issue = (state_reg == ST_SCAN);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.adv && status.pair_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        stall_next = (state_next != ST_IDLE);
    end

    // State and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    `ASSERT_CLK(a_done_in_drain, clk, rst_n, status.done |-> (state_reg == ST_DRAIN))
    `ASSERT_CLK(a_scan_to_drain, clk, rst_n, (state_reg == ST_SCAN && status.adv && status.pair_last) |=> (state_reg == ST_DRAIN))
    `ASSERT_NEVER(a_start_busy, clk, rst_n, cmd.start && (state_reg != ST_IDLE))

endmodule

// ----- hw/rtl/lbos_dp.sv -----
// Datapath of the box overlap scan: slot table, pair counter, overlap
// pipeline and result buffering. Depends on lbos_pkg, lbos_ram, assert_macros.svh.
`include "assert_macros.svh"

module lbos_dp #(
    parameter int MAX_BOXES = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lbos_pkg::cmd_t                       cmd,
    output lbos_pkg::status_t                    status,
    input  logic [lbos_pkg::IDX_W-1:0]           box_index,
    input  logic                                 box_enabled,
    input  logic                                 has_handler,
    input  logic [lbos_pkg::LAYER_W-1:0]         layer_from,
    input  logic [lbos_pkg::LAYER_W-1:0]         layer_to,
    input  logic signed [lbos_pkg::POS_W-1:0]    centre_x,
    input  logic signed [lbos_pkg::POS_W-1:0]    centre_y,
    input  logic [lbos_pkg::EXT_W-1:0]           extent_x,
    input  logic [lbos_pkg::EXT_W-1:0]           extent_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lbos_pkg::IDX_W-1:0]           source_slot,
    output logic [lbos_pkg::IDX_W-1:0]           target_slot,
    output logic                                 hit,
    output logic                                 last
);

    localparam int SLOT_W = $clog2(MAX_BOXES);
    localparam int IDX_W1 = lbos_pkg::IDX_W + 1;
    localparam int WORD_W = $bits(lbos_pkg::slot_t);
    localparam int EPAD_W = lbos_pkg::EDGE_W - lbos_pkg::EXT_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(MAX_BOXES - 1);
    localparam logic [IDX_W1-1:0] SLOT_LIMIT = IDX_W1'(MAX_BOXES);

    // Edges of one axis for one pair
    typedef struct packed {
        logic [lbos_pkg::EDGE_W-1:0] ra;
        logic [lbos_pkg::EDGE_W-1:0] la;
        logic [lbos_pkg::EDGE_W-1:0] rb;
        logic [lbos_pkg::EDGE_W-1:0] lb;
        logic [lbos_pkg::SPAN_W-1:0] span;
    } axis_t;

    // Form Q.1 edges and the span limit of one axis
    function automatic axis_t axis_edges(
        input logic [lbos_pkg::POS_W-1:0] ca,
        input logic [lbos_pkg::EXT_W-1:0] sa,
        input logic [lbos_pkg::POS_W-1:0] cb,
        input logic [lbos_pkg::EXT_W-1:0] sb
    );
        axis_t                       r;
        logic [lbos_pkg::EDGE_W-1:0] dca;
        logic [lbos_pkg::EDGE_W-1:0] dcb;
        logic [lbos_pkg::EDGE_W-1:0] esa;
        logic [lbos_pkg::EDGE_W-1:0] esb;
        dca    = {ca[lbos_pkg::POS_W-1], ca, 1'b0};
        dcb    = {cb[lbos_pkg::POS_W-1], cb, 1'b0};
        esa    = {{EPAD_W{1'b0}}, sa};
        esb    = {{EPAD_W{1'b0}}, sb};
        r.ra   = dca + esa;
        r.la   = dca - esa;
        r.rb   = dcb + esb;
        r.lb   = dcb - esb;
        r.span = {({1'b0, sa} + {1'b0, sb}), 1'b0};
        return r;
    endfunction

    // Inclusive overlap: max(right) - min(left) <= 2*(sa + sb)
    function automatic logic axis_overlap(input axis_t a);
        logic [lbos_pkg::EDGE_W-1:0] hi;
        logic [lbos_pkg::EDGE_W-1:0] lo;
        logic [lbos_pkg::EDGE_W-1:0] diff;
        hi   = ($signed(a.ra) > $signed(a.rb)) ? a.ra : a.rb;
        lo   = ($signed(a.la) < $signed(a.lb)) ? a.la : a.lb;
        diff = hi - lo;
        return diff <= {1'b0, a.span};
    endfunction

    logic                  adv;
    logic                  issue_now;
    logic                  wr_ok;
    logic [SLOT_W-1:0]     wr_addr;
    lbos_pkg::slot_t       wr_word;
    lbos_pkg::slot_t       rd_a;
    lbos_pkg::slot_t       rd_b;
    logic [WORD_W-1:0]     rd_data_a;
    logic [WORD_W-1:0]     rd_data_b;
    logic [MAX_BOXES-1:0]  vld_reg;

    logic [SLOT_W-1:0]     s_reg;
    logic [SLOT_W-1:0]     t_reg;

    logic                  v1_reg;
    logic                  end1_reg;
    logic [SLOT_W-1:0]     s1_reg;
    logic [SLOT_W-1:0]     t1_reg;
    logic                  vs1_reg;
    logic                  vt1_reg;
    logic                  ok1;

    logic                  v2_reg;
    logic                  end2_reg;
    logic                  ok2_reg;
    logic [SLOT_W-1:0]     s2_reg;
    logic [SLOT_W-1:0]     t2_reg;
    axis_t                 ax2_reg;
    axis_t                 ay2_reg;

    logic                  hit_now;
    logic                  fin_end;

    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [SLOT_W-1:0]     pend_s_reg;
    logic [SLOT_W-1:0]     pend_s_next;
    logic [SLOT_W-1:0]     pend_t_reg;
    logic [SLOT_W-1:0]     pend_t_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [SLOT_W-1:0]     out_src_reg;
    logic [SLOT_W-1:0]     out_src_next;
    logic [SLOT_W-1:0]     out_tgt_reg;
    logic [SLOT_W-1:0]     out_tgt_next;
    logic                  out_hit_reg;
    logic                  out_hit_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    // Pipeline moves whenever the output register is free or being taken
    assign adv       = !out_valid_reg || !out_stall;
    assign issue_now = cmd.issue && adv;

    assign status.adv       = adv;
    assign status.pair_last = (s_reg == SLOT_LAST) && (t_reg == SLOT_LAST);
    assign status.done      = fin_end && adv;

    // Slot write: drop writes beyond the table
    assign wr_ok   = cmd.wr_en && ({1'b0, box_index} < SLOT_LIMIT);
    assign wr_addr = box_index[SLOT_W-1:0];

    always_comb
    begin
        wr_word            = '0;
        wr_word.enabled    = box_enabled;
        wr_word.handler    = has_handler;
        wr_word.layer_from = layer_from;
        wr_word.layer_to   = layer_to;
        wr_word.centre_x   = centre_x;
        wr_word.centre_y   = centre_y;
        wr_word.extent_x   = extent_x;
        wr_word.extent_y   = extent_y;
    end

    lbos_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BOXES)
    ) u_slot_ram (
        .clk       (clk),
        .wr_en     (wr_ok),
        .wr_addr   (wr_addr),
        .wr_data   (wr_word),
        .rd_en     (adv),
        .rd_addr_a (s_reg),
        .rd_data_a (rd_data_a),
        .rd_addr_b (t_reg),
        .rd_data_b (rd_data_b)
    );

    assign rd_a = lbos_pkg::slot_t'(rd_data_a);
    assign rd_b = lbos_pkg::slot_t'(rd_data_b);

    // Mark written slots; an unwritten slot reads as disabled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_ok)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Advance the pair counter, target inner
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
            t_reg <= '0;
        end
        else if (cmd.start)
        begin
            s_reg <= '0;
            t_reg <= '0;
        end
        else if (issue_now)
        begin
            if (t_reg == SLOT_LAST)
            begin
                t_reg <= '0;
                s_reg <= s_reg + 1'b1;
            end
            else
            begin
                t_reg <= t_reg + 1'b1;
            end
        end
    end

    // Stage 1: slot data arrives from the RAM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            end1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg   <= issue_now;
            end1_reg <= issue_now && status.pair_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s_reg;
            t1_reg  <= t_reg;
            vs1_reg <= vld_reg[s_reg];
            vt1_reg <= vld_reg[t_reg];
        end
    end

    // Pair qualifies on flags, layers and distinct slots
    assign ok1 = vs1_reg && rd_a.enabled && (rd_a.layer_to != '0) &&
                 (rd_a.layer_to == rd_b.layer_from) &&
                 vt1_reg && rd_b.enabled && rd_b.handler && (s1_reg != t1_reg);

    // Stage 2: hold edges and span limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg   <= 1'b0;
            end2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg   <= v1_reg;
            end2_reg <= end1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok2_reg <= ok1;
            s2_reg  <= s1_reg;
            t2_reg  <= t1_reg;
            ax2_reg <= axis_edges(rd_a.centre_x, rd_a.extent_x,
                                  rd_b.centre_x, rd_b.extent_x);
            ay2_reg <= axis_edges(rd_a.centre_y, rd_a.extent_y,
                                  rd_b.centre_y, rd_b.extent_y);
        end
    end

    assign hit_now = v2_reg && ok2_reg && axis_overlap(ax2_reg) && axis_overlap(ay2_reg);
    assign fin_end = v2_reg && end2_reg;

    // Hold one hit back so the final one can carry last
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_s_next     = pend_s_reg;
        pend_t_next     = pend_t_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_src_next    = out_src_reg;
        out_tgt_next    = out_tgt_reg;
        out_hit_next    = out_hit_reg;
        out_last_next   = out_last_reg;
        if (adv)
        begin
            priority if (fin_end)
            begin
                out_valid_next  = 1'b1;
                out_last_next   = 1'b1;
                out_hit_next    = pend_valid_reg;
                out_src_next    = pend_valid_reg ? pend_s_reg : '0;
                out_tgt_next    = pend_valid_reg ? pend_t_reg : '0;
                pend_valid_next = 1'b0;
            end
            else if (hit_now)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    out_hit_next   = 1'b1;
                    out_src_next   = pend_s_reg;
                    out_tgt_next   = pend_t_reg;
                end
                pend_valid_next = 1'b1;
                pend_s_next     = s2_reg;
                pend_t_next     = t2_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_s_reg   <= pend_s_next;
        pend_t_reg   <= pend_t_next;
        out_src_reg  <= out_src_next;
        out_tgt_reg  <= out_tgt_next;
        out_hit_reg  <= out_hit_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign source_slot = lbos_pkg::IDX_W'(out_src_reg);
    assign target_slot = lbos_pkg::IDX_W'(out_tgt_reg);
    assign hit         = out_hit_reg;
    assign last        = out_last_reg;

    `ASSERT_CLK(a_end_clears_pend, clk, rst_n, (v2_reg && end2_reg && adv) |=> !pend_valid_reg)
    `ASSERT_NEVER(a_self_hit, clk, rst_n, out_valid_reg && out_hit_reg && (out_src_reg == out_tgt_reg))
    `ASSERT_CLK(a_marker_last, clk, rst_n, (out_valid_reg && !out_hit_reg) |-> out_last_reg)

endmodule

// ----- hw/rtl/layered_box_overlap_scan_top.sv -----
// Layered box overlap scan: a table of up to MAX_BOXES axis-aligned boxes
// with an all-pairs overlap scan.
//
// Input channel (in_valid / in_stall): req_type 0 writes the slot named by
// box_index with all box fields; writes to slots at or above MAX_BOXES are
// dropped. A write leaves in_stall low; the next request is taken right after.
// req_type 1 starts a scan of every ordered slot pair, source outer, target
// inner, one pair per cycle through a three-stage read and compare pipeline
// while the output is not stalled. A scan holds in_stall high until its
// final result enters the output register; output stalls prolong it.
// Output channel (out_valid / out_stall): one result per overlapping pair,
// the final one of a scan flagged with last. A scan with no collision gives
// a single result with hit 0 and last 1. One hit is held back until the next
// hit or the end of the scan is known. A stalled output freezes the whole
// pipeline; nothing is lost. Reset clears every slot to disabled and empties
// the pipeline.
// Depends on lbos_pkg, lbos_ctrl, lbos_dp and lbos_ram.
module layered_box_overlap_scan_top #(
    parameter int MAX_BOXES = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [lbos_pkg::IDX_W-1:0]         box_index,
    input  logic                               box_enabled,
    input  logic                               has_handler,
    input  logic [lbos_pkg::LAYER_W-1:0]       layer_from,
    input  logic [lbos_pkg::LAYER_W-1:0]       layer_to,
    input  logic signed [lbos_pkg::POS_W-1:0]  centre_x,
    input  logic signed [lbos_pkg::POS_W-1:0]  centre_y,
    input  logic [lbos_pkg::EXT_W-1:0]         extent_x,
    input  logic [lbos_pkg::EXT_W-1:0]         extent_y,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lbos_pkg::IDX_W-1:0]         source_slot,
    output logic [lbos_pkg::IDX_W-1:0]         target_slot,
    output logic                               hit,
    output logic                               last
);

    lbos_pkg::cmd_t    cmd;
    lbos_pkg::status_t status;

    // Request sequencing
    lbos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .cmd      (cmd),
        .status   (status)
    );

    // Slot table and pair pipeline
    lbos_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .box_index   (box_index),
        .box_enabled (box_enabled),
        .has_handler (has_handler),
        .layer_from  (layer_from),
        .layer_to    (layer_to),
        .centre_x    (centre_x),
        .centre_y    (centre_y),
        .extent_x    (extent_x),
        .extent_y    (extent_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .source_slot (source_slot),
        .target_slot (target_slot),
        .hit         (hit),
        .last        (last)
    );

endmodule
